### hw/rtl/fpdhc_pkg.sv
// Package for the fuzzy PD heading controller: formats, constants, shared
// types and the command/status structs between controller and datapath.
`default_nettype none
package fpdhc_pkg;

  localparam int unsigned AngleW = 15;
  localparam int unsigned GainW  = 16;
  localparam int unsigned LevelW = 15;
  localparam int unsigned NormW  = 16;
  localparam int unsigned DriveW = 18;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgErrorGain   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRateGain    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOutputGain  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLevelSmall  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLevelMedium = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLevelBig    = 3'd5;

  localparam logic signed [17:0] PiQ12    = 18'sd12868;
  localparam logic signed [17:0] TwoPiQ12 = 18'sd25736;
  localparam logic signed [17:0] QOne     = 18'sd16384;

  // divider: 33-bit magnitude quotient (acc up to ~2^30 / sum >= 1)
  localparam int unsigned DivNW = 33;
  localparam int unsigned DivDW = 18;
  localparam int unsigned DivCntW = 6;

  // reciprocals of the fixed set edge widths, scaled by 2^RecipSh
  localparam int unsigned RecipSh = 40;
  localparam logic [31:0] Recip819  = 32'(((64'd1 << RecipSh) + 64'd818) / 64'd819);
  localparam logic [31:0] Recip1786 = 32'(((64'd1 << RecipSh) + 64'd1785) / 64'd1786);
  localparam logic [31:0] Recip1802 = 32'(((64'd1 << RecipSh) + 64'd1801) / 64'd1802);
  localparam logic [31:0] Recip1818 = 32'(((64'd1 << RecipSh) + 64'd1817) / 64'd1818);
  localparam logic [31:0] Recip6554 = 32'(((64'd1 << RecipSh) + 64'd6553) / 64'd6554);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_FUZZ,
    ST_RULES,
    ST_DIV,
    ST_OUT,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic load;
    logic scale;
    logic fuzz;
    logic div_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  // ramp num*16384/den rounded, num <= den, den from the fixed table with its reciprocal
  function automatic logic [14:0] deg_div(input logic [15:0] num, input logic [15:0] den,
                                          input logic [31:0] recip);
    logic [30:0] n;
    logic [62:0] p;
    n = {num, 14'd0} + {15'd0, den[15:1]};
    p = {32'd0, n} * {31'd0, recip};
    return p[RecipSh +: 15];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/fpdhc_ctrl.sv
// Controller state machine for the fuzzy PD heading controller.
// Depends on fpdhc_pkg.
`default_nettype none
module fpdhc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output fpdhc_pkg::cmd_t    cmd,
  input  wire fpdhc_pkg::sts_t sts
);
  import fpdhc_pkg::*;

  state_t state_r, state_nxt;
  logic   full_r, full_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      full_r  <= full_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    full_nxt = full_r;
    if (full_r && !out_stall) full_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_FUZZ;
      end
      ST_FUZZ: begin
        cmd.fuzz = 1'b1;
        state_nxt = ST_RULES;
      end
      ST_RULES: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!full_r || !out_stall) begin
          cmd.finish = 1'b1;
          full_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = full_r;
endmodule
`default_nettype wire

### hw/rtl/fpdhc_dpath.sv
// Datapath: error wrap, scaling, fuzzification, rules, serial divider,
// output gain and output register. Depends on fpdhc_pkg.
`default_nettype none
module fpdhc_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire fpdhc_pkg::cmd_t                   cmd,
  output fpdhc_pkg::sts_t                        sts,
  input  wire logic                              cfg_we,
  input  wire logic [fpdhc_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [fpdhc_pkg::CfgDataW-1:0]    cfg_data,
  input  wire logic signed [fpdhc_pkg::AngleW-1:0] in_setpoint_angle,
  input  wire logic signed [fpdhc_pkg::AngleW-1:0] in_measured_angle,
  output logic signed [fpdhc_pkg::DriveW-1:0]    out_drive,
  output logic signed [fpdhc_pkg::NormW-1:0]     out_normalized_output,
  output logic signed [fpdhc_pkg::NormW-1:0]     out_normalized_error,
  output logic signed [fpdhc_pkg::NormW-1:0]     out_normalized_rate
);
  import fpdhc_pkg::*;

  logic [15:0] eg_r, rg_r, og_r;
  logic [14:0] ls_r, lm_r, lb_r;
  logic signed [15:0] ep_r, ep2_r, ek_r;
  logic signed [15:0] pe_r, dr_r;
  logic [14:0] enb_r, ens_r, eze_r, eps_r, epb_r, rne_r, rze_r, rpo_r;
  logic [17:0] sum_r;
  logic [DivNW-1:0] q_r, rem_r;
  logic [DivCntW-1:0] cnt_r;
  logic busy_r, neg_r, zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eg_r <= 16'd651; rg_r <= 16'd12792; og_r <= 16'd2816;
      ls_r <= 15'd2458; lm_r <= 15'd8192; lb_r <= 15'd11469;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgErrorGain:   eg_r <= cfg_data;
        CfgRateGain:    rg_r <= cfg_data;
        CfgOutputGain:  og_r <= cfg_data;
        CfgLevelSmall:  ls_r <= cfg_data[14:0];
        CfgLevelMedium: lm_r <= cfg_data[14:0];
        CfgLevelBig:    lb_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // wrap
  logic signed [17:0] d0, d1, d2;
  always_comb begin
    d0 = 18'(in_setpoint_angle) - 18'(in_measured_angle);
    d1 = (d0 < -PiQ12) ? d0 + TwoPiQ12 : d0;
    d2 = (d1 > PiQ12) ? d1 - TwoPiQ12 : d1;
  end

  function automatic logic signed [15:0] rnd_clamp(input logic signed [47:0] v);
    logic [47:0] m;
    logic signed [47:0] r;
    m = v[47] ? 48'(-v) : v;
    m = (m + 48'd512) >> 10;
    r = v[47] ? -$signed(m) : $signed(m);
    if (r > 48'sd16384) return 16'sd16384;
    if (r < -48'sd16384) return -16'sd16384;
    return 16'(r);
  endfunction

  logic signed [47:0] pm, rm;
  always_comb begin
    pm = $signed({32'd0, eg_r}) * 48'(ek_r);
    rm = $signed({32'd0, rg_r}) * (48'(ek_r) - 48'(ep2_r)) * 48'sd10;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ep_r <= '0; ep2_r <= '0;
    end else if (cmd.load) begin
      ek_r <= d2[15:0];
    end else if (cmd.scale) begin
      pe_r <= rnd_clamp(pm);
      dr_r <= rnd_clamp(rm);
      ep2_r <= ep_r;
      ep_r <= ek_r;
    end
  end

  function automatic logic [14:0] tri_f(input logic signed [15:0] x,
      input logic signed [15:0] a, input logic signed [15:0] b,
      input logic signed [15:0] c, input logic [31:0] rl, input logic [31:0] rr);
    if (x < a) return 15'd0;
    if (x <= b) return deg_div(16'(x - a), 16'(b - a), rl);
    if (x <= c) return deg_div(16'(c - x), 16'(c - b), rr);
    return 15'd0;
  endfunction

  function automatic logic [14:0] nbig(input logic signed [15:0] x);
    if (x <= -16'sd3604) return 15'd16384;
    if (x <= -16'sd2785) return deg_div(16'(-16'sd2785 - x), 16'd819, Recip819);
    return 15'd0;
  endfunction

  function automatic logic [14:0] pbig(input logic signed [15:0] x);
    if (x < 16'sd2785) return 15'd0;
    if (x <= 16'sd3604) return deg_div(16'(x - 16'sd2785), 16'd819, Recip819);
    return 15'd16384;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.fuzz) begin
      enb_r <= nbig(pe_r);
      ens_r <= tri_f(pe_r, -16'sd3604, -16'sd1802, 16'sd16, Recip1802, Recip1818);
      eze_r <= tri_f(pe_r, -16'sd1802, 16'sd0, 16'sd1802, Recip1802, Recip1802);
      eps_r <= tri_f(pe_r, 16'sd16, 16'sd1802, 16'sd3604, Recip1786, Recip1802);
      epb_r <= pbig(pe_r);
      rne_r <= nbig(dr_r);
      rze_r <= tri_f(dr_r, -16'sd6554, 16'sd0, 16'sd6554, Recip6554, Recip6554);
      rpo_r <= pbig(dr_r);
    end
  end

  function automatic logic [14:0] mn(input logic [14:0] p, input logic [14:0] q);
    return (p < q) ? p : q;
  endfunction
  function automatic logic [14:0] mx(input logic [14:0] p, input logic [14:0] q);
    return (p > q) ? p : q;
  endfunction

  logic [14:0] wnb, wnm, wns, wze, wps, wpm, wpb;
  logic signed [31:0] acc_c;
  always_comb begin
    wnb = mn(enb_r, rne_r);
    wnm = mx(mn(enb_r, rze_r), mn(ens_r, rne_r));
    wns = mx(mx(mn(enb_r, rpo_r), mn(ens_r, rze_r)), mn(eze_r, rne_r));
    wze = mx(mx(mn(ens_r, rpo_r), mn(eze_r, rze_r)), mn(eps_r, rne_r));
    wps = mx(mx(mn(eze_r, rpo_r), mn(eps_r, rze_r)), mn(epb_r, rne_r));
    wpm = mx(mn(eps_r, rpo_r), mn(epb_r, rze_r));
    wpb = mn(epb_r, rpo_r);
    acc_c = $signed({17'd0, lb_r}) * (32'(wpb) - 32'(wnb))
          + $signed({17'd0, lm_r}) * (32'(wpm) - 32'(wnm))
          + $signed({17'd0, ls_r}) * (32'(wps) - 32'(wns));
  end

  // restoring divider, one quotient bit per cycle
  logic [DivNW-1:0] un;
  logic [DivNW:0] trial;
  always_comb begin
    un = acc_c[31] ? DivNW'(-acc_c) : DivNW'(acc_c);
    trial = {rem_r, q_r[DivNW-1]} - {{(DivNW+1-DivDW){1'b0}}, sum_r};
  end

  logic [17:0] sum_c;
  assign sum_c = 18'(wnb) + 18'(wnm) + 18'(wns) + 18'(wze) + 18'(wps) + 18'(wpm)
               + 18'(wpb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (cmd.div_start) begin
      busy_r <= 1'b1;
      cnt_r <= DivCntW'(DivNW);
      sum_r <= sum_c;
      neg_r <= acc_c[31];
      zero_r <= (sum_c == 18'd0);
      q_r <= un + DivNW'(sum_c[17:1]);
      rem_r <= '0;
    end else if (busy_r) begin
      if (trial[DivNW]) begin
        rem_r <= {rem_r[DivNW-2:0], q_r[DivNW-1]};
        q_r <= {q_r[DivNW-2:0], 1'b0};
      end else begin
        rem_r <= trial[DivNW-1:0];
        q_r <= {q_r[DivNW-2:0], 1'b1};
      end
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DivCntW'(1)) busy_r <= 1'b0;
    end
  end
  assign sts.div_done = !busy_r;

  logic signed [17:0] u_c;
  logic signed [35:0] dm;
  logic [35:0] dmag;
  logic signed [17:0] drv_c;
  always_comb begin
    if (zero_r) u_c = '0;
    else if (q_r > DivNW'(16384)) u_c = neg_r ? -QOne : QOne;
    else u_c = neg_r ? -$signed(18'(q_r)) : $signed(18'(q_r));
    dm = $signed({20'd0, og_r}) * 36'(u_c);
    dmag = dm[35] ? 36'(-dm) : dm;
    dmag = (dmag + 36'd8192) >> 14;
    drv_c = dm[35] ? -$signed(18'(dmag)) : $signed(18'(dmag));
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_drive <= drv_c;
      out_normalized_output <= 16'(u_c);
      out_normalized_error <= pe_r;
      out_normalized_rate <= dr_r;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/fuzzy_pd_heading_controller.sv
// Top level of the fuzzy PD heading controller: controller plus datapath.
// Depends on fpdhc_pkg, fpdhc_ctrl, fpdhc_dpath.
//
// Usage: present setpoint and measured angle (Q3.12) with in_valid; the item
// transfers when in_stall is low. The result (drive, normalized output, error
// and rate) appears with out_valid and transfers when out_stall is low.
// From input transfer to out_valid an item passes wrap, scale, fuzzify, rules,
// 33 divider steps, the divider-finish state and the output register load.
// One item is in flight at a time: a new item is taken only after the last
// has been loaded into the output register. The output register holds one
// result, so a new item is taken while a finished result waits; a stalled
// result holds until taken and the next item waits at the output stage.
// Reset (rst_n low, synchronous) restores default gains and levels and clears
// the error history. cfg_we writes register cfg_index; the user must do so
// only while idle, as the block itself does not enforce it.
`default_nettype none
module fuzzy_pd_heading_controller (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic signed [fpdhc_pkg::AngleW-1:0] in_setpoint_angle,
  input  wire logic signed [fpdhc_pkg::AngleW-1:0] in_measured_angle,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic signed [fpdhc_pkg::DriveW-1:0] out_drive,
  output logic signed [fpdhc_pkg::NormW-1:0]  out_normalized_output,
  output logic signed [fpdhc_pkg::NormW-1:0]  out_normalized_error,
  output logic signed [fpdhc_pkg::NormW-1:0]  out_normalized_rate,
  input  wire logic cfg_we,
  input  wire logic [fpdhc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [fpdhc_pkg::CfgDataW-1:0] cfg_data
);
  import fpdhc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fpdhc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  fpdhc_dpath u_dpath (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_index, .cfg_data,
    .in_setpoint_angle, .in_measured_angle, .out_drive,
    .out_normalized_output, .out_normalized_error, .out_normalized_rate
  );
endmodule
`default_nettype wire
